### rtl/core/ctb_pkg.sv
// Shared types and constants for the countdown timer bank.
package ctb_pkg;

  localparam int unsigned NUM_TIMERS = 8;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned TV_W    = 15;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned TPS_W   = 8;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned CID_W   = (NUM_TIMERS > (1 << IDX_W)) ? $clog2(NUM_TIMERS) : IDX_W;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  localparam logic [TPS_W-1:0] TPS_RESET     = 8'd18;
  localparam logic [TV_W-1:0]  SECONDS_LIMIT = 15'd100;

  // x / 100 == (x * 5243) >> 19 for every 15-bit x
  localparam int unsigned      RECIP_SH = 19;
  localparam int unsigned      PROD_W   = TV_W + 13;
  localparam logic [12:0]      RECIP    = 13'd5243;

  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  ticks;
    logic [MASK_W-1:0] mask;
  } cmd_t;

endpackage

### rtl/core/ctb_convert.sv
// Front stage: converts the timeout value to ticks and registers the request.
module ctb_convert import ctb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [OP_W-1:0]  opcode_i,
  input  logic [IDX_W-1:0] timer_index_i,
  input  logic [TV_W-1:0]  timeout_value_i,
  input  logic [TPS_W-1:0] tps_i,
  output cmd_t             cmd_o
);

  logic [CNT_W-1:0]  sec_ticks;
  logic [PROD_W-1:0] div_prod;
  logic [CNT_W-1:0]  ticks;
  logic              valid_q;
  cmd_t              pay_q;

  always_comb begin
    sec_ticks = CNT_W'(timeout_value_i[6:0] * tps_i);
    div_prod  = PROD_W'(timeout_value_i) * PROD_W'(RECIP);
    if (timeout_value_i < SECONDS_LIMIT) begin
      ticks = sec_ticks;
    end else begin
      ticks = CNT_W'(div_prod[PROD_W-1:RECIP_SH]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pay_q.valid <= 1'b0;
      pay_q.op    <= opcode_i;
      pay_q.idx   <= timer_index_i;
      pay_q.ticks <= ticks;
      pay_q.mask  <= '0;
    end
  end

  always_comb begin
    cmd_o       = pay_q;
    cmd_o.valid = valid_q;
  end

endmodule

### rtl/core/ctb_cell.sv
// One timer cell: counter and flag, applies the passing request, adds its flag.
module ctb_cell import ctb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [CID_W-1:0] cell_id_i,
  input  cmd_t             cmd_i,
  output cmd_t             cmd_o
);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              flag_q, flag_d;
  logic              hit;
  logic [MASK_W-1:0] mask_d;
  logic              valid_q;
  cmd_t              pay_q;

  assign hit = (CID_W'(cmd_i.idx) == cell_id_i);

  always_comb begin
    cnt_d  = cnt_q;
    flag_d = flag_q;
    case (cmd_i.op)
      OP_TICK: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            flag_d = 1'b1;
          end
        end
      end
      OP_START: begin
        if (hit) begin
          cnt_d  = cmd_i.ticks;
          flag_d = 1'b0;
        end
      end
      OP_STOP: begin
        if (hit) begin
          cnt_d  = '0;
          flag_d = 1'b0;
        end
      end
      default: ;
    endcase
    mask_d = cmd_i.mask;
    if (32'(cell_id_i) < MASK_W) begin
      mask_d[cell_id_i[IDX_W-1:0]] = flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      flag_q  <= 1'b0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= cmd_i.valid;
      if (cmd_i.valid) begin
        cnt_q  <= cnt_d;
        flag_q <= flag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pay_q.valid <= cmd_i.valid;
      pay_q.op    <= cmd_i.op;
      pay_q.idx   <= cmd_i.idx;
      pay_q.ticks <= cmd_i.ticks;
      pay_q.mask  <= mask_d;
    end
  end

  always_comb begin
    cmd_o       = pay_q;
    cmd_o.valid = valid_q;
  end

endmodule

### rtl/core/countdown_timer_bank.sv
// Top level of the countdown timer bank.
//
// Requests enter on in_valid_i/in_ready_o with opcode_i (tick, start, stop),
// timer_index_i and timeout_value_i. Every request returns one response on
// out_valid_o/out_ready_i carrying expired_mask_o, the flags after that request.
// ticks_per_second_i is written when ticks_per_second_we_i is high; the user must write it
// only while no request is in flight, and the block itself does not enforce this.
// A request passes a conversion stage, then walks the row of NUM_TIMERS cells,
// one cell per cycle while the row advances; each cell updates its own timer and adds its flag bit.
// One request is taken per cycle while no response waits unaccepted.
// The row advances as a whole: while a response waits unaccepted, in_ready_o
// is low and every stage holds.
// Reset clears all counters and flags, empties the row and loads
// ticks_per_second with 18.
module countdown_timer_bank import ctb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [IDX_W-1:0]  timer_index_i,
  input  logic [TV_W-1:0]   timeout_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MASK_W-1:0] expired_mask_o,
  input  logic              ticks_per_second_we_i,
  input  logic [TPS_W-1:0]  ticks_per_second_i
);

  logic [TPS_W-1:0] tps_q;
  logic             adv;
  cmd_t             chain [NUM_TIMERS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (ticks_per_second_we_i) begin
      tps_q <= ticks_per_second_i;
    end
  end

  assign adv        = !chain[NUM_TIMERS].valid || out_ready_i;
  assign in_ready_o = adv;

  ctb_convert u_convert (
    .clk_i,
    .rst_ni,
    .adv_i           (adv),
    .valid_i         (in_valid_i),
    .opcode_i,
    .timer_index_i,
    .timeout_value_i,
    .tps_i           (tps_q),
    .cmd_o           (chain[0])
  );

  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    ctb_cell u_cell (
      .clk_i,
      .rst_ni,
      .adv_i     (adv),
      .cell_id_i (CID_W'(k)),
      .cmd_i     (chain[k]),
      .cmd_o     (chain[k+1])
    );
  end

  assign out_valid_o    = chain[NUM_TIMERS].valid;
  assign expired_mask_o = chain[NUM_TIMERS].mask;

endmodule

### rtl/core/ctb_checker.sv
// Port-level checks for the countdown timer bank, bound to the top level.
module ctb_checker import ctb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [MASK_W-1:0] expired_mask_o
);

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while response stalled");

  a_idle_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with empty output");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("response dropped");

  a_mask_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(expired_mask_o))
    else $error("response changed while stalled");

endmodule

bind countdown_timer_bank ctb_checker u_ctb_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the countdown timer bank: directed and random requests.
module tb_top import ctb_pkg::*;;

  localparam int unsigned TICK_DIVISOR = 100;
  localparam int unsigned MAX_GAP      = 20;
  localparam int unsigned MAX_PRINTS   = 20;

  logic              clk_i                 = 1'b0;
  logic              rst_ni                = 1'b0;
  logic              in_valid_i            = 1'b0;
  logic              in_ready_o;
  logic [OP_W-1:0]   opcode_i              = OP_TICK;
  logic [IDX_W-1:0]  timer_index_i         = '0;
  logic [TV_W-1:0]   timeout_value_i       = '0;
  logic              out_valid_o;
  logic              out_ready_i           = 1'b0;
  logic [MASK_W-1:0] expired_mask_o;
  logic              ticks_per_second_we_i = 1'b0;
  logic [TPS_W-1:0]  ticks_per_second_i    = '0;

  logic [CNT_W-1:0]      timer_cnt [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] timer_expired;
  logic [TPS_W-1:0]      tick_rate;
  logic [MASK_W-1:0]     mask_q [$];
  logic [MASK_W-1:0]     exp_mask;

  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_idle_pct  = 0;
  int unsigned err_cnt       = 0;
  int unsigned n_tick        = 0;
  int unsigned n_start       = 0;
  int unsigned n_stop        = 0;
  int unsigned n_expired_rsp = 0;

  countdown_timer_bank i_dut (.*);

  always #10 clk_i = ~clk_i;

  initial begin
    #(2_000_000);
    $display("timeout: %0d responses still pending", mask_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) begin
      $display("%0t: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  function automatic void clear_timers();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_cnt[i] = '0;
    end
    timer_expired = '0;
    tick_rate     = TPS_RESET;
  endfunction

  function automatic logic [MASK_W-1:0] apply_request(input logic [OP_W-1:0] op,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [TV_W-1:0] tv);
    logic [TV_W+TPS_W-1:0] scaled;
    scaled = tv * tick_rate;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (timer_cnt[i] != '0) begin
            timer_cnt[i] = timer_cnt[i] - 1'b1;
            if (timer_cnt[i] == '0) begin
              timer_expired[i] = 1'b1;
            end
          end
        end
      end
      OP_START: begin
        if (idx < NUM_TIMERS) begin
          timer_cnt[idx]     = (tv < SECONDS_LIMIT) ? scaled[CNT_W-1:0]
                                                    : CNT_W'(tv / TICK_DIVISOR);
          timer_expired[idx] = 1'b0;
        end
      end
      OP_STOP: begin
        if (idx < NUM_TIMERS) begin
          timer_cnt[idx]     = '0;
          timer_expired[idx] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return MASK_W'(timer_expired);
  endfunction

  // valid is left high after acceptance so back-to-back requests need no toggle
  task automatic send_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                          input logic [TV_W-1:0] tv);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    timer_index_i   <= idx;
    timeout_value_i <= tv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    mask_q.push_back(apply_request(op, idx, tv));
    case (op)
      OP_TICK:  n_tick++;
      OP_START: n_start++;
      OP_STOP:  n_stop++;
      default: begin
      end
    endcase
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (mask_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_tick_rate(input logic [TPS_W-1:0] rate);
    wait_idle();
    ticks_per_second_we_i <= 1'b1;
    ticks_per_second_i    <= rate;
    @(posedge clk_i);
    ticks_per_second_we_i <= 1'b0;
    tick_rate = rate;
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (mask_q.size() == 0) begin
        report_mismatch($sformatf("unexpected response, mask %h", expired_mask_o));
      end else begin
        exp_mask = mask_q.pop_front();
        if (expired_mask_o !== exp_mask) begin
          report_mismatch($sformatf("expired_mask: expected %h, got %h",
                                    exp_mask, expired_mask_o));
        end
        if (exp_mask != '0) begin
          n_expired_rsp++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // conversion edges at the reset tick rate, expiry, flag lifetime, stop
  task automatic test_conversion_and_expiry();
    send_req(OP_START, 0, 1);
    send_req(OP_START, 1, 99);
    send_req(OP_START, 2, 0);
    send_req(OP_START, 3, 100);
    send_req(OP_START, 4, 199);
    send_req(OP_START, 5, 200);
    send_req(OP_START, 6, 32767);
    send_req(OP_START, 7, 150);
    send_req(OP_TICK, 0, 0);
    send_req(OP_TICK, 7, 32767);
    send_req(OP_STOP, 3, 0);
    send_req(OP_START, 4, 150);
    send_req(OP_TICK, 0, 0);
    send_req(OP_TICK, 0, 0);
    send_req(OP_STOP, 2, 0);
  endtask

  task automatic test_tick_rate_extremes();
    write_tick_rate(8'd255);
    send_req(OP_START, 0, 99);
    send_req(OP_START, 1, 1);
    write_tick_rate(8'd1);
    send_req(OP_START, 2, 1);
    send_req(OP_START, 3, 99);
    send_req(OP_TICK, 0, 0);
    send_req(OP_STOP, 2, 0);
  endtask

  // mostly short timeouts and ticks so timers actually run out
  task automatic test_random_traffic(input int unsigned n, input int unsigned snd,
                                     input int unsigned rcv, input logic [TPS_W-1:0] rate);
    int unsigned      pick;
    logic [IDX_W-1:0] idx;
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    write_tick_rate(rate);
    repeat (n) begin
      pick = $urandom_range(99);
      idx  = IDX_W'($urandom_range(2**IDX_W - 1));
      if (pick < 45) begin
        send_req(OP_TICK, IDX_W'($urandom), TV_W'($urandom));
      end else if (pick < 78) begin
        send_req(OP_START, idx, $urandom_range(1) ? TV_W'($urandom_range(100, 999))
                                                  : TV_W'($urandom_range(3)));
      end else if (pick < 90) begin
        send_req(OP_STOP, idx, TV_W'($urandom));
      end else begin
        send_req(OP_START, idx, TV_W'($urandom_range(2**TV_W - 1)));
      end
    end
  endtask

  initial begin
    clear_timers();
    snd_idle_pct = 9;
    rcv_idle_pct = 74;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_conversion_and_expiry();
    test_tick_rate_extremes();
    test_random_traffic(145, 9, 74, 8'd1);
    test_random_traffic(145, 74, 9, 8'd255);
    test_random_traffic(145, 0, 0, TPS_W'($urandom_range(2, 20)));

    wait_idle();
    repeat (NUM_TIMERS + 4) @(posedge clk_i);
    $display("covered %0d ticks, %0d starts, %0d stops at tick rates 18, 255, 1 and random",
             n_tick, n_start, n_stop);
    $display("%0d responses showed an expired timer, %0d errors", n_expired_rsp, err_cnt);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ctb_pkg.sv
rtl/core/ctb_convert.sv
rtl/core/ctb_cell.sv
rtl/core/countdown_timer_bank.sv
rtl/core/ctb_checker.sv
verif/tb_top.sv
